>>> rtl/rq_pkg.sv
// Retransmit queue package: opcodes, result kinds, sequencer states,
// table entry and result structures. No dependencies.
`default_nettype none
package rq_pkg;

  localparam int OCC_W  = 6;
  localparam int SLOT_W = 5;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 136;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_CONFIRM = 3'd1,
    OP_EXISTS  = 3'd2,
    OP_TICK    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    K_ADDED     = 4'd0,
    K_FULL      = 4'd1,
    K_CONFIRMED = 4'd2,
    K_NOTFOUND  = 4'd3,
    K_EXISTS    = 4'd4,
    K_ABSENT    = 4'd5,
    K_DROPPED   = 4'd6,
    K_RESEND    = 4'd7,
    K_CLEARED   = 4'd8,
    K_DONE      = 4'd9
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_RD,
    ST_EV,
    ST_MISS,
    ST_DONE
  } state_e;

  localparam logic [0:0] REG_INTERVAL = 1'b0;
  localparam logic [0:0] REG_LIMIT    = 1'b1;

  typedef struct packed {
    logic [7:0]  retries;
    logic [31:0] sent;
    logic [15:0] size;
    logic [15:0] port;
    logic [31:0] address;
    logic [15:0] handle;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [3:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       stamp;
    logic [15:0]       handle;
    logic [31:0]       address;
    logic [15:0]       port;
    logic [15:0]       size;
    logic [7:0]        retries;
    logic [OCC_W-1:0]  occupancy;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/rq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module rq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/rq_outbuf.sv
// Result output register for the retransmit queue; packs a result onto
// the master stream. Depends on rq_pkg.
`default_nettype none
module rq_outbuf (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            load_i,
  input  wire rq_pkg::result_t                 res_i,
  output logic                                 free_o,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [rq_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic [3:0]                           m_axis_tuser,
  output logic                                 m_axis_tlast
);

  logic            valid_q, valid_d;
  rq_pkg::result_t res_q;

  assign free_o  = !valid_q || m_axis_tready;
  assign valid_d = load_i ? 1'b1 : (m_axis_tready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {5'd0, res_q.occupancy, res_q.retries, res_q.size, res_q.port,
                          res_q.address, res_q.handle, res_q.stamp, res_q.slot};

endmodule
`default_nettype wire

>>> rtl/retransmit_queue_core.sv
// Retransmit queue top level: request sequencer around the entry RAM.
// Depends on rq_pkg, rq_ram, rq_outbuf.
//
// Use:
//  - Slave stream takes one request: tuser = opcode (add, confirm, exists,
//    tick, clear), tdata = stamp, peer address, port, handle, size, now.
//  - Master stream returns one or more results per request, the final one
//    of kind done with tlast high. tuser = kind, tdata = entry fields.
//  - cfg_we_i/cfg_idx_i/cfg_wdata_i write retry_interval (0) and
//    retry_limit (1); write only while the block is idle.
//  - One request at a time: s_axis_tready is high only when idle.
//  - Walks read the entry RAM one entry at a time (address, then evaluate
//    against the registered read data), set by the single RAM read port;
//    tick walks the table in a drop pass and then a resend pass.
//  - Removed entries are compacted in the same walk by writing survivors
//    to a lower write pointer; the write never touches a not-yet-read row.
//  - A stalled receiver freezes the walk on the entry whose result waits.
//  - Reset empties the table and restores the default registers; the RAM
//    contents are not cleared.
`default_nettype none
module retransmit_queue_core #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // stamp, peer_address, dest_port, frame_handle, frame_size, now
  input  wire logic [rq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // opcode
  input  wire logic [2:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // slot, entry_stamp, entry_handle, entry_address, entry_port,
  // entry_size, entry_retries, occupancy, zero pad
  output logic [rq_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // kind
  output logic [3:0]                             m_axis_tuser,
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_we_i,
  input  wire logic [0:0]                        cfg_idx_i,
  input  wire logic [31:0]                       cfg_wdata_i
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = rq_pkg::OCC_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  rq_pkg::state_e state_q, state_d;

  // request latch
  logic [2:0]  op_q, op_d;
  logic [31:0] stamp_q, stamp_d, addr_q, addr_d, now_q, now_d;
  logic [15:0] port_q, port_d, handle_q, handle_d, size_q, size_d;

  // walk control
  logic [CW-1:0] cnt_q, cnt_d, r_q, r_d, w_q, w_d, end_q, end_d;
  logic          found_q, found_d, phase_q, phase_d;

  logic [31:0] interval_q;
  logic [7:0]  limit_q;

  // RAM
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  rq_pkg::entry_t              ram_wdata, ent, ent_upd;
  logic [rq_pkg::ENTRY_W-1:0]  ram_rdata;

  // result path
  logic            out_free, out_load;
  rq_pkg::result_t res;

  logic        accept, is_match, is_drop, is_late, last_idx, want_emit, stall;
  logic [31:0] age;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign ent      = rq_pkg::entry_t'(ram_rdata);
  assign is_match = ent.stamp == stamp_q;
  assign is_drop  = ent.retries > limit_q;
  assign age      = now_q - ent.sent;
  assign is_late  = age > interval_q;
  assign last_idx = (r_q + ONE_C) == end_q;

  always_comb begin
    ent_upd         = ent;
    ent_upd.sent    = now_q;
    ent_upd.retries = (ent.retries == 8'hFF) ? ent.retries : ent.retries + 8'd1;
  end

  always_comb begin
    case (op_q)
      rq_pkg::OP_EXISTS:  want_emit = is_match;
      rq_pkg::OP_CONFIRM: want_emit = is_match && !found_q;
      rq_pkg::OP_TICK:    want_emit = phase_q ? is_late : is_drop;
      rq_pkg::OP_CLEAR:   want_emit = 1'b1;
      default:            want_emit = 1'b0;
    endcase
  end

  assign stall = want_emit && !out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rq_pkg::ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            rq_pkg::OP_ADD: state_d = rq_pkg::ST_ADD;
            rq_pkg::OP_CONFIRM, rq_pkg::OP_EXISTS:
              state_d = (cnt_q == '0) ? rq_pkg::ST_MISS : rq_pkg::ST_RD;
            rq_pkg::OP_TICK, rq_pkg::OP_CLEAR:
              state_d = (cnt_q == '0) ? rq_pkg::ST_DONE : rq_pkg::ST_RD;
            default: state_d = rq_pkg::ST_DONE;
          endcase
        end
      end
      rq_pkg::ST_ADD:  if (out_free) state_d = rq_pkg::ST_DONE;
      rq_pkg::ST_RD:   state_d = rq_pkg::ST_EV;
      rq_pkg::ST_EV: begin
        if (!stall) begin
          if (op_q == rq_pkg::OP_EXISTS && is_match) begin
            state_d = rq_pkg::ST_DONE;
          end else if (last_idx) begin
            if (op_q == rq_pkg::OP_TICK && !phase_q) begin
              state_d = (cnt_d == '0) ? rq_pkg::ST_DONE : rq_pkg::ST_RD;
            end else if ((op_q == rq_pkg::OP_CONFIRM || op_q == rq_pkg::OP_EXISTS)
                         && !found_d) begin
              state_d = rq_pkg::ST_MISS;
            end else begin
              state_d = rq_pkg::ST_DONE;
            end
          end else begin
            state_d = rq_pkg::ST_RD;
          end
        end
      end
      rq_pkg::ST_MISS: if (out_free) state_d = rq_pkg::ST_DONE;
      rq_pkg::ST_DONE: if (out_free) state_d = rq_pkg::ST_IDLE;
      default: state_d = rq_pkg::ST_IDLE;
    endcase
  end

  // outputs, RAM access and datapath
  always_comb begin
    op_d = op_q; stamp_d = stamp_q; addr_d = addr_q; now_d = now_q;
    port_d = port_q; handle_d = handle_q; size_d = size_q;
    cnt_d = cnt_q; r_d = r_q; w_d = w_q; end_d = end_q;
    found_d = found_q; phase_d = phase_q;
    ram_we = 1'b0; ram_waddr = w_q[AW-1:0]; ram_wdata = ent;
    out_load = 1'b0;
    res = '0;
    res.occupancy = cnt_q;

    case (state_q)
      rq_pkg::ST_IDLE: begin
        if (accept) begin
          op_d     = s_axis_tuser;
          stamp_d  = s_axis_tdata[31:0];
          addr_d   = s_axis_tdata[63:32];
          port_d   = s_axis_tdata[79:64];
          handle_d = s_axis_tdata[95:80];
          size_d   = s_axis_tdata[111:96];
          now_d    = s_axis_tdata[143:112];
          r_d = '0; w_d = '0; end_d = cnt_q;
          found_d = 1'b0; phase_d = 1'b0;
        end
      end
      rq_pkg::ST_ADD: begin
        if (cnt_q >= DEPTH_C) begin
          res.kind = rq_pkg::K_FULL;
          out_load = out_free;
        end else begin
          res.kind      = rq_pkg::K_ADDED;
          res.slot      = cnt_q[rq_pkg::SLOT_W-1:0];
          res.stamp     = stamp_q;
          res.handle    = handle_q;
          res.address   = addr_q;
          res.port      = port_q;
          res.size      = size_q;
          res.occupancy = cnt_q + ONE_C;
          ram_waddr         = cnt_q[AW-1:0];
          ram_wdata.stamp   = stamp_q;
          ram_wdata.handle  = handle_q;
          ram_wdata.address = addr_q;
          ram_wdata.port    = port_q;
          ram_wdata.size    = size_q;
          ram_wdata.sent    = now_q;
          ram_wdata.retries = 8'd0;
          if (out_free) begin
            out_load = 1'b1;
            ram_we   = 1'b1;
            cnt_d    = cnt_q + ONE_C;
          end
        end
      end
      rq_pkg::ST_EV: begin
        res.slot    = r_q[rq_pkg::SLOT_W-1:0];
        res.stamp   = ent.stamp;
        res.handle  = ent.handle;
        res.address = ent.address;
        res.port    = ent.port;
        res.size    = ent.size;
        res.retries = ent.retries;
        if (!stall) begin
          out_load = want_emit;
          case (op_q)
            rq_pkg::OP_EXISTS: begin
              res.kind = rq_pkg::K_EXISTS;
              if (is_match) found_d = 1'b1;
            end
            rq_pkg::OP_CONFIRM: begin
              res.kind = rq_pkg::K_CONFIRMED;
              res.occupancy = cnt_q - ONE_C;
              if (want_emit) begin
                found_d = 1'b1;
                cnt_d   = cnt_q - ONE_C;
              end else begin
                ram_we = 1'b1;
                w_d    = w_q + ONE_C;
              end
            end
            rq_pkg::OP_TICK: begin
              if (!phase_q) begin
                // drop pass: survivors move down to the write pointer
                res.kind      = rq_pkg::K_DROPPED;
                res.slot      = w_q[rq_pkg::SLOT_W-1:0];
                res.occupancy = cnt_q - ONE_C;
                if (is_drop) begin
                  cnt_d = cnt_q - ONE_C;
                end else begin
                  ram_we = 1'b1;
                  w_d    = w_q + ONE_C;
                end
              end else begin
                res.kind    = rq_pkg::K_RESEND;
                res.retries = ent_upd.retries;
                ram_waddr   = r_q[AW-1:0];
                ram_wdata   = ent_upd;
                ram_we      = is_late;
              end
            end
            rq_pkg::OP_CLEAR: begin
              res.kind      = rq_pkg::K_CLEARED;
              res.occupancy = cnt_q - ONE_C;
              cnt_d         = cnt_q - ONE_C;
            end
            default: res.kind = rq_pkg::K_DONE;
          endcase
          r_d = r_q + ONE_C;
          if (last_idx && op_q == rq_pkg::OP_TICK && !phase_q) begin
            phase_d = 1'b1;
            r_d     = '0;
            end_d   = cnt_d;
          end
        end
      end
      rq_pkg::ST_MISS: begin
        res.kind = (op_q == rq_pkg::OP_EXISTS) ? rq_pkg::K_ABSENT : rq_pkg::K_NOTFOUND;
        out_load = out_free;
      end
      rq_pkg::ST_DONE: begin
        res.kind = rq_pkg::K_DONE;
        res.last = 1'b1;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = state_q == rq_pkg::ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rq_pkg::ST_IDLE;
      cnt_q      <= '0;
      r_q        <= '0;
      w_q        <= '0;
      end_q      <= '0;
      found_q    <= 1'b0;
      phase_q    <= 1'b0;
      op_q       <= '0;
      interval_q <= 32'd1000;
      limit_q    <= 8'd3;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      r_q     <= r_d;
      w_q     <= w_d;
      end_q   <= end_d;
      found_q <= found_d;
      phase_q <= phase_d;
      op_q    <= op_d;
      if (cfg_we_i && cfg_idx_i == rq_pkg::REG_INTERVAL) interval_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == rq_pkg::REG_LIMIT)    limit_q    <= cfg_wdata_i[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    stamp_q  <= stamp_d;
    addr_q   <= addr_d;
    now_q    <= now_d;
    port_q   <= port_d;
    handle_q <= handle_d;
    size_q   <= size_d;
  end

  rq_ram #(
    .WIDTH (rq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (r_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  rq_outbuf u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

>>> rtl/rq_checker.sv
// Port-level checks for the retransmit queue, bound to the top level.
// Depends on rq_pkg and retransmit_queue_core.
`default_nettype none
module rq_checker #(
  parameter int QUEUE_DEPTH = 32
) (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [rq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input wire logic [3:0]                       m_axis_tuser,
  input wire logic                             m_axis_tlast
);

  // one request in flight: no new request right after one is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == rq_pkg::K_DONE)))
    else $error("tlast not on done result");

  a_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[130:125] <= 6'(QUEUE_DEPTH))
    else $error("occupancy beyond depth");

  a_done_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[124:0] == '0)
    else $error("done result carries entry data");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind retransmit_queue_core rq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
